// ===== rtl/core/column_median_decimator_assert.svh =====
// Assertion macros for the top-level RTL file, which checks itself.
`ifndef COLUMN_MEDIAN_DECIMATOR_ASSERT_SVH
`define COLUMN_MEDIAN_DECIMATOR_ASSERT_SVH

// same-cycle implication
`define CMD_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("column median decimator: assertion failed");

// next-cycle implication
`define CMD_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("column median decimator: assertion failed");

`endif

// ===== rtl/core/cmd_pkg.sv =====
`default_nettype none
package cmd_pkg;

    localparam int WINDOW_MAX_DEF = 100;
    localparam int MAX_ROWS_DEF   = 1024;

    localparam logic [15:0] PAD_VALUE        = 16'hFFFF;
    localparam logic [6:0]  WINDOW_LEN_RESET = 7'd100;
    localparam logic [7:0]  STRIDE_RESET     = 8'd10;

    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic REG_STRIDE     = 1'b1;

    typedef struct packed {
        logic [15:0] depth;
        logic        column_end;
    } sample_t;

    typedef struct packed {
        logic [15:0] median_value;
        logic [9:0]  row_index;
        logic        last_of_column;
    } result_t;

    typedef struct packed {
        logic accept;
        logic finish;
        logic mod_start;
        logic mod_step;
        logic med_start;
        logic med_load;
        logic med_shift;
        logic out_load_median;
        logic out_load_pad;
    } dp_cmd_t;

    typedef struct packed {
        logic pending;
        logic mod_done;
        logic mod_zero;
        logic load_done;
        logic shift_done;
        logic out_taken;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/cmd_ram.sv =====
`default_nettype none
module cmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/cmd_datapath.sv =====
`default_nettype none
module cmd_datapath #(
    parameter int WINDOW_MAX = 100,
    parameter int MAX_ROWS   = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [6:0]        window_len,
    input  wire logic [7:0]        stride,
    input  wire cmd_pkg::dp_cmd_t  cmd,
    output cmd_pkg::dp_stat_t      stat,
    input  wire cmd_pkg::sample_t  sample,
    output cmd_pkg::result_t       result,
    output logic                   result_valid,
    input  wire logic              result_ready
);
    import cmd_pkg::*;

    localparam int SW  = $clog2(WINDOW_MAX);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int EW  = RW + 8;
    localparam int AW  = SW + 8;
    localparam int MCW = $clog2(RW + 1);

    logic [6:0]    len_eff;
    logic [5:0]    half;
    logic [6:0]    lag;
    logic [7:0]    s_eff;

    logic [RW-1:0] in_row_reg;
    logic [SW-1:0] in_slot_reg;
    logic [RW:0]   out_row_reg;
    logic [SW-1:0] out_slot_reg;
    logic          end_reg;
    logic          any_reg;
    logic [RW-1:0] limit_reg;

    logic [7:0]    rem_reg;
    logic [RW-1:0] mq_reg;
    logic [MCW-1:0] mcnt_reg;

    logic [6:0]    k_reg;
    logic signed [EW-1:0] row_reg;
    logic [SW-1:0] rd_slot_reg;
    logic          pv_reg;
    logic          pr_reg;
    logic [5:0]    sh_reg;

    logic [15:0]   sorted_reg [WINDOW_MAX];
    logic [15:0]   rdata;

    result_t       result_reg;
    logic          result_valid_reg;

    logic          end_c;
    logic [EW-1:0] diff_ext;
    logic [8:0]    trial;
    logic [AW-1:0] start_slot;
    logic          issue;
    logic          real_row;
    logic [WINDOW_MAX-1:0] gt;
    logic [RW+9:0] row_wide;

    assign len_eff = (window_len == 7'd0) ? 7'd1 :
                     (window_len > 7'(WINDOW_MAX)) ? 7'(WINDOW_MAX) : window_len;
    assign half    = len_eff[6:1];
    assign lag     = len_eff - 7'd1 - {1'b0, half};
    assign s_eff   = (stride == 8'd0) ? 8'd1 : stride;

    assign end_c    = sample.column_end || (in_row_reg >= RW'(MAX_ROWS - 1));
    assign diff_ext = EW'(in_row_reg) - EW'(lag);
    assign trial    = {rem_reg, mq_reg[RW-1]};
    assign start_slot = (AW'(out_slot_reg) < AW'(half)) ?
                        AW'(out_slot_reg) + AW'(WINDOW_MAX) - AW'(half) :
                        AW'(out_slot_reg) - AW'(half);
    assign issue    = cmd.med_load && (k_reg < len_eff);
    assign real_row = !row_reg[EW-1] && (row_reg <= $signed(EW'(in_row_reg)));

    always_comb
    begin
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            gt[j] = sorted_reg[j] > rdata;
        end
    end

    cmd_ram #(
        .WIDTH(16),
        .DEPTH(WINDOW_MAX)
    ) u_window_ram (
        .clk  (clk),
        .we   (cmd.accept),
        .waddr(in_slot_reg),
        .wdata(sample.depth),
        .raddr(rd_slot_reg),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg       <= '0;
            in_slot_reg      <= '0;
            out_row_reg      <= '0;
            out_slot_reg     <= '0;
            end_reg          <= 1'b0;
            any_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            mcnt_reg         <= '0;
            k_reg            <= '0;
            pv_reg           <= 1'b0;
            sh_reg           <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                end_reg <= end_c;
                any_reg <= end_c || (EW'(in_row_reg) >= EW'(lag));
            end
            if (cmd.finish)
            begin
                if (end_reg)
                begin
                    in_row_reg   <= '0;
                    in_slot_reg  <= '0;
                    out_row_reg  <= '0;
                    out_slot_reg <= '0;
                end
                else
                begin
                    in_row_reg  <= in_row_reg + RW'(1);
                    in_slot_reg <= (in_slot_reg == SW'(WINDOW_MAX - 1)) ? '0 :
                                   in_slot_reg + SW'(1);
                end
            end
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
                out_row_reg      <= out_row_reg + (RW+1)'(1);
                out_slot_reg     <= (out_slot_reg == SW'(WINDOW_MAX - 1)) ? '0 :
                                    out_slot_reg + SW'(1);
            end
            else if (cmd.out_load_median || cmd.out_load_pad)
            begin
                result_valid_reg <= 1'b1;
            end
            if (cmd.mod_start)
            begin
                mcnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                mcnt_reg <= mcnt_reg + MCW'(1);
            end
            if (cmd.med_start)
            begin
                k_reg  <= '0;
                pv_reg <= 1'b0;
                sh_reg <= '0;
            end
            else
            begin
                if (cmd.med_load)
                begin
                    pv_reg <= issue;
                    if (issue)
                    begin
                        k_reg <= k_reg + 7'd1;
                    end
                end
                if (cmd.med_shift)
                begin
                    sh_reg <= sh_reg + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            limit_reg <= end_c ? in_row_reg : diff_ext[RW-1:0];
        end
        if (cmd.mod_start)
        begin
            rem_reg <= '0;
            mq_reg  <= out_row_reg[RW-1:0];
        end
        else if (cmd.mod_step)
        begin
            rem_reg <= (trial >= {1'b0, s_eff}) ? 8'(trial - {1'b0, s_eff}) : trial[7:0];
            mq_reg  <= mq_reg << 1;
        end
        if (cmd.med_start)
        begin
            row_reg     <= $signed(EW'(out_row_reg[RW-1:0])) - $signed(EW'(half));
            rd_slot_reg <= start_slot[SW-1:0];
            for (int j = 0; j < WINDOW_MAX; j++)
            begin
                sorted_reg[j] <= PAD_VALUE;
            end
        end
        else
        begin
            if (issue)
            begin
                pr_reg      <= real_row;
                row_reg     <= row_reg + EW'(1);
                rd_slot_reg <= (rd_slot_reg == SW'(WINDOW_MAX - 1)) ? '0 :
                               rd_slot_reg + SW'(1);
            end
            if (cmd.med_load && pv_reg && pr_reg)
            begin
                for (int j = 0; j < WINDOW_MAX; j++)
                begin
                    if (j > 0 && gt[j > 0 ? j - 1 : 0])
                    begin
                        sorted_reg[j] <= sorted_reg[j > 0 ? j - 1 : 0];
                    end
                    else if (gt[j])
                    begin
                        sorted_reg[j] <= rdata;
                    end
                end
            end
            else if (cmd.med_shift)
            begin
                for (int j = 0; j < WINDOW_MAX; j++)
                begin
                    sorted_reg[j] <= (j == WINDOW_MAX - 1) ? PAD_VALUE :
                                     sorted_reg[j < WINDOW_MAX - 1 ? j + 1 : j];
                end
            end
        end
        if (cmd.out_load_median || cmd.out_load_pad)
        begin
            result_reg.median_value   <= cmd.out_load_median ? sorted_reg[0] : PAD_VALUE;
            result_reg.row_index      <= row_wide[9:0];
            result_reg.last_of_column <= end_reg && (out_row_reg == {1'b0, in_row_reg});
        end
    end

    assign row_wide = {10'd0, out_row_reg[RW-1:0]};

    assign stat.pending    = any_reg && (out_row_reg <= {1'b0, limit_reg});
    assign stat.mod_done   = (mcnt_reg == MCW'(RW));
    assign stat.mod_zero   = (rem_reg == 8'd0);
    assign stat.load_done  = (k_reg >= len_eff) && !pv_reg;
    assign stat.shift_done = (sh_reg == half);
    assign stat.out_taken  = result_valid_reg && result_ready;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/core/cmd_ctrl.sv =====
`default_nettype none
module cmd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire cmd_pkg::dp_stat_t stat,
    output cmd_pkg::dp_cmd_t       cmd
);
    import cmd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.pending)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                if (!stat.mod_done)
                begin
                    cmd.mod_step = 1'b1;
                end
                else if (stat.mod_zero)
                begin
                    cmd.med_start = 1'b1;
                    state_next    = ST_LOAD;
                end
                else
                begin
                    cmd.out_load_pad = 1'b1;
                    state_next       = ST_OUT;
                end
            end
            ST_LOAD:
            begin
                if (stat.load_done)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    cmd.med_load = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    cmd.out_load_median = 1'b1;
                    state_next          = ST_OUT;
                end
                else
                begin
                    cmd.med_shift = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (stat.out_taken)
                begin
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/column_median_decimator.sv =====
// One sample is taken per visit to idle; it then releases zero or more results.
// A padded (non-stride) result uses only the remainder unit; a median result uses the
// remainder unit, serial RAM reads into the insertion array, then the shift to the
// median slot. A sample that releases nothing is accepted and finished; each result
// is held until taken.
// Reset: rows restart at zero, window_len 100, stride 10; the RAM is not cleared.
`default_nettype none
`include "column_median_decimator_assert.svh"
module column_median_decimator #(
    parameter int WINDOW_MAX = cmd_pkg::WINDOW_MAX_DEF,
    parameter int MAX_ROWS   = cmd_pkg::MAX_ROWS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    input  wire logic             sample_valid,
    output logic                  sample_ready,
    input  wire cmd_pkg::sample_t sample,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output cmd_pkg::result_t      result
);
    import cmd_pkg::*;

    logic [6:0] window_len_reg;
    logic [7:0] stride_reg;
    logic       wr_en;
    dp_cmd_t    cmd;
    dp_stat_t   stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_STRIDE) ? {24'd0, stride_reg} : {25'd0, window_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RESET;
            stride_reg     <= STRIDE_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_WINDOW_LEN)
            begin
                window_len_reg <= pwdata[6:0];
            end
            else
            begin
                stride_reg <= pwdata[7:0];
            end
        end
    end

    cmd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    cmd_datapath #(
        .WINDOW_MAX(WINDOW_MAX),
        .MAX_ROWS  (MAX_ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .window_len  (window_len_reg),
        .stride      (stride_reg),
        .cmd         (cmd),
        .stat        (stat),
        .sample      (sample),
        .result      (result),
        .result_valid(result_valid),
        .result_ready(result_ready)
    );

    `CMD_ASSERT_IMPLY(a_busy_while_result, clk, rst_n, result_valid, !sample_ready)
    `CMD_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, sample_valid && sample_ready, !sample_ready)
    `CMD_ASSERT_NEXT(a_no_result_after_idle, clk, rst_n, sample_ready && !sample_valid, !result_valid)

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import cmd_pkg::*;

    localparam int WMAX = WINDOW_MAX_DEF;
    localparam int NROWS = MAX_ROWS_DEF;
    localparam int STALL_LIMIT = 200000;
    localparam logic [2:0] ADDR_WINDOW_LEN = 3'(4 * REG_WINDOW_LEN);
    localparam logic [2:0] ADDR_STRIDE = 3'(4 * REG_STRIDE);

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic sample_valid, sample_ready;
    sample_t sample;
    logic result_valid, result_ready;
    result_t result;

    column_median_decimator u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    // predictor state
    logic [6:0] cur_len;
    logic [7:0] cur_stride;
    logic [15:0] depth_ring [WMAX];
    int in_row, out_row;

    sample_t pending_samples[$];
    result_t expected_results[$];
    int errors = 0;
    bit quiet_mode = 0;
    int hold_cycles = 0;
    bit hold_req = 0;
    int stall_count = 0;
    bit in_fire = 0;

    function automatic logic [15:0] window_median(int i, int last_row, int len);
        logic [15:0] vals[$];
        int row;
        for (int k = 0; k < len; k++)
        begin
            row = i - len / 2 + k;
            if (row < 0 || row > last_row)
                vals.push_back(PAD_VALUE);
            else
                vals.push_back(depth_ring[row % WMAX]);
        end
        vals.sort();
        return vals[len / 2];
    endfunction

    task automatic predict_sample(sample_t s);
        int r, len, lag, st, limit;
        bit fin, any;
        result_t e;
        r = in_row;
        len = (cur_len == 0) ? 1 : (cur_len > WMAX ? WMAX : int'(cur_len));
        lag = len - 1 - len / 2;
        st = (cur_stride == 0) ? 1 : int'(cur_stride);
        fin = s.column_end;
        if (r >= NROWS - 1)
            fin = 1;
        depth_ring[r % WMAX] = s.depth;
        any = 1;
        limit = 0;
        if (fin)
            limit = r;
        else if (r >= lag)
            limit = r - lag;
        else
            any = 0;
        if (any)
        begin
            for (int n = 0; n < 64 && out_row <= limit; n++)
            begin
                e.median_value = (out_row % st == 0) ? window_median(out_row, r, len)
                                                     : PAD_VALUE;
                e.row_index = 10'(out_row);
                e.last_of_column = fin && (out_row == r);
                expected_results.push_back(e);
                out_row++;
            end
        end
        if (fin)
        begin
            in_row = 0;
            out_row = 0;
        end
        else
            in_row = r + 1;
    endtask

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !in_fire)
                ;
            else if (pending_samples.size() > 0 && (quiet_mode || $urandom_range(99) >= 38))
            begin
                sample <= pending_samples.pop_front();
                sample_valid <= 1;
            end
            else
                sample_valid <= 0;
            if (hold_req)
            begin
                hold_cycles <= hold_cycles + 1;
                result_ready <= 0;
            end
            else
                result_ready <= quiet_mode || ($urandom_range(99) >= 38);
        end
    end

    // accepted beats feed the predictor; predict at the posedge that takes them
    always @(posedge clk)
    begin
        in_fire = rst_n && sample_valid && sample_ready;
        if (in_fire)
            predict_sample(sample);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result row %0d", result.row_index);
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                if (result.median_value !== e.median_value)
                begin
                    $error("median_value exp %0d got %0d", e.median_value, result.median_value);
                    errors++;
                end
                if (result.row_index !== e.row_index)
                begin
                    $error("row_index exp %0d got %0d", e.row_index, result.row_index);
                    errors++;
                end
                if (result.last_of_column !== e.last_of_column)
                begin
                    $error("last_of_column exp %0d got %0d", e.last_of_column,
                           result.last_of_column);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready) || !rst_n
            || hold_req)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == ADDR_WINDOW_LEN)
            cur_len = data[6:0];
        else
            cur_len = cur_len;
        if (addr == ADDR_STRIDE)
            cur_stride = data[7:0];
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    task automatic push_column(int rows, bit wide_values);
        sample_t s;
        for (int k = 0; k < rows; k++)
        begin
            s.depth = wide_values ? 16'($urandom) : 16'($urandom_range(2000, 1000));
            if ($urandom_range(9) == 0)
                s.depth = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            s.column_end = (k == rows - 1);
            pending_samples.push_back(s);
        end
    endtask

    initial
    begin
        sample_t s;
        int lens[6];
        int strides[6];
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        sample_valid = 0; sample = '0; result_ready = 0;
        cur_len = WINDOW_LEN_RESET;
        cur_stride = STRIDE_RESET;
        for (int k = 0; k < WMAX; k++)
            depth_ring[k] = PAD_VALUE;
        in_row = 0;
        out_row = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: reset settings, extremes, single-row column
        s = '{depth: 16'h0000, column_end: 1'b0}; pending_samples.push_back(s);
        s = '{depth: 16'hFFFF, column_end: 1'b0}; pending_samples.push_back(s);
        s = '{depth: 16'h5555, column_end: 1'b0}; pending_samples.push_back(s);
        s = '{depth: 16'hAAAA, column_end: 1'b1}; pending_samples.push_back(s);
        s = '{depth: 16'h1234, column_end: 1'b1}; pending_samples.push_back(s);
        drain();
        write_reg(ADDR_WINDOW_LEN, 32'd0);
        write_reg(ADDR_STRIDE, 32'd0);
        push_column(6, 1);
        drain();
        write_reg(ADDR_WINDOW_LEN, 32'd127);
        write_reg(ADDR_STRIDE, 32'd255);
        push_column(5, 1);
        drain();
        write_reg(ADDR_WINDOW_LEN, 32'd2);
        write_reg(ADDR_STRIDE, 32'd1);
        push_column(8, 1);

        // hold off the receiver so the input stalls
        hold_req = 1;
        wait (hold_cycles >= 400);
        hold_req = 0;
        drain();

        // random phases
        lens = '{1, 3, 4, 7, 16, 100};
        strides = '{1, 2, 3, 5, 10, 255};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(ADDR_WINDOW_LEN, 32'(lens[$urandom_range(5)]));
            write_reg(ADDR_STRIDE, 32'(strides[$urandom_range(5)]));
            for (int c = 0; c < 4; c++)
                push_column($urandom_range(20, 1), $urandom_range(1));
            if (ph == 3)
                quiet_mode = 1;
            drain();
            quiet_mode = 0;
        end

        if (errors == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cmd_pkg.sv
rtl/core/cmd_ram.sv
rtl/core/cmd_datapath.sv
rtl/core/cmd_ctrl.sv
rtl/core/column_median_decimator.sv
tb/testbench.sv
